// File: design/tsss_pkg.sv
`default_nettype none

package tsss_pkg;

  localparam int unsigned NumPos = 8;
  localparam int unsigned PosW   = $clog2(NumPos);
  localparam int unsigned RawW   = 12;
  localparam int unsigned SegW   = 8;

  typedef logic [SegW-1:0]              seg_t;
  typedef logic [NumPos-1:0][SegW-1:0]  seg_set_t;
  typedef logic [PosW-1:0]              pos_t;

  localparam seg_t SegC     = 8'h39;
  localparam seg_t SegMinus = 8'h40;
  localparam seg_t SegDp    = 8'h80;
  localparam seg_t SegBlank = 8'h00;
  localparam pos_t LastPos  = pos_t'(NumPos - 1);

  // scan positions, rightmost first
  localparam pos_t PosGlyph  = 3'd0;
  localparam pos_t PosHundth = 3'd1;
  localparam pos_t PosTenth  = 3'd2;
  localparam pos_t PosUnits  = 3'd3;
  localparam pos_t PosTens   = 3'd4;
  localparam pos_t PosHundr  = 3'd5;
  localparam pos_t PosSign   = 3'd6;
  localparam pos_t PosSpare  = 3'd7;

  function automatic seg_t seg_code(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

  // x / 10 by reciprocal, exact for x <= 159
  function automatic logic [3:0] div10(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd205;
    return prod[14:11];
  endfunction

endpackage

`default_nettype wire

// File: design/temperature_to_seven_segment_scan_top.sv
// Path: an accepted item is registered in the input stage, then loaded into the
// scan registers once the scanner is free; the eight results then follow on
// consecutive cycles. The single result port paces items: a new item is taken
// by the scanner during the last result of the previous one.
// Reset: synchronous, active low; clears the input and scan valid state.
// The receiver cannot stall: out_valid marks each result for one cycle.
`default_nettype none

module temperature_to_seven_segment_scan_top
  import tsss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [RawW-1:0] in_raw_temperature,
  output logic                        out_valid,
  output pos_t                        out_digit_position,
  output seg_t                        out_segment_pattern,
  output logic                        out_last_position
);

  logic                   in_valid_r, in_valid_nxt;
  logic signed [RawW-1:0] in_r;
  logic                   accept;
  logic                   load_ok;
  seg_set_t               pats;

  // input stage holds an item until the scanner takes it
  assign busy   = in_valid_r && !load_ok;
  assign accept = start && !busy;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (load_ok) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_raw_temperature;
    end
  end

  tsss_digits u_digits (
    .raw  (in_r),
    .pats (pats)
  );

  tsss_scan u_scan (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load_req            (in_valid_r),
    .pats                (pats),
    .load_ok             (load_ok),
    .out_valid           (out_valid),
    .out_digit_position  (out_digit_position),
    .out_segment_pattern (out_segment_pattern),
    .out_last_position   (out_last_position)
  );

endmodule

`default_nettype wire

// File: design/tsss_digits.sv
`default_nettype none

module tsss_digits
  import tsss_pkg::*;
(
  input  wire logic signed [RawW-1:0] raw,
  output seg_set_t                    pats
);

  logic             neg;
  logic [RawW-1:0]  mag;
  logic [7:0]       int_part;
  logic [3:0]       frac;
  logic [8:0]       frac_sc;
  logic [6:0]       frac_h;
  logic [3:0]       q1, q2, qf;
  logic [7:0]       rem_u, rem_t, rem_f;
  logic [3:0]       d_units, d_tens, d_hundr, d_tenth, d_hundth;

  // v = int_part*100 + round(frac*6.25), so each part splits on its own
  always_comb begin
    neg      = raw[RawW-1];
    mag      = neg ? (RawW'(0) - RawW'(raw)) : RawW'(raw);
    int_part = mag[RawW-1:4];
    frac     = mag[3:0];
    frac_sc  = 9'(frac) * 9'd25 + 9'd2;
    frac_h   = frac_sc[8:2];

    q1       = div10(int_part);
    rem_u    = int_part - 8'(q1) * 8'd10;
    q2       = div10(8'(q1));
    rem_t    = 8'(q1) - 8'(q2) * 8'd10;
    qf       = div10(8'(frac_h));
    rem_f    = 8'(frac_h) - 8'(qf) * 8'd10;

    d_units  = rem_u[3:0];
    d_tens   = rem_t[3:0];
    d_hundr  = q2;
    d_tenth  = qf;
    d_hundth = rem_f[3:0];

    pats            = '0;
    pats[PosGlyph]  = SegC;
    pats[PosHundth] = seg_code(d_hundth);
    pats[PosTenth]  = seg_code(d_tenth);
    pats[PosUnits]  = seg_code(d_units) | SegDp;
    pats[PosTens]   = (int_part >= 8'd10)  ? seg_code(d_tens)  : SegBlank;
    pats[PosHundr]  = (int_part >= 8'd100) ? seg_code(d_hundr) : SegBlank;
    pats[PosSign]   = neg ? SegMinus : SegBlank;
    pats[PosSpare]  = SegBlank;
  end

endmodule

`default_nettype wire

// File: design/tsss_scan.sv
`default_nettype none

module tsss_scan
  import tsss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load_req,
  input  seg_set_t  pats,
  output logic      load_ok,
  output logic      out_valid,
  output pos_t      out_digit_position,
  output seg_t      out_segment_pattern,
  output logic      out_last_position
);

  logic     active_r, active_nxt;
  pos_t     pos_r, pos_nxt;
  seg_set_t pat_r;
  logic     load;

  // free again on the final position, so items chain without a gap
  assign load_ok = !active_r || (pos_r == LastPos);
  assign load    = load_req && load_ok;

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    if (load) begin
      active_nxt = 1'b1;
      pos_nxt    = '0;
    end else if (active_r) begin
      pos_nxt = pos_r + pos_t'(1);
      if (pos_r == LastPos) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r <= pats;
    end
  end

  assign out_valid           = active_r;
  assign out_digit_position  = pos_r;
  assign out_segment_pattern = pat_r[pos_r];
  assign out_last_position   = active_r && (pos_r == LastPos);

endmodule

`default_nettype wire

// File: design/tsss_checker.sv
`default_nettype none

module tsss_checker
  import tsss_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire pos_t                   out_digit_position,
  input wire seg_t                   out_segment_pattern,
  input wire logic                   out_last_position
);

  // a scan never breaks off before its final position
  a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_position |=>
      out_valid && (out_digit_position == $past(out_digit_position) + pos_t'(1)))
    else $error("scan broke off or skipped a position");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_position == (out_digit_position == LastPos)))
    else $error("last flag out of step with position");

  a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_digit_position == PosGlyph) |-> out_segment_pattern == SegC)
    else $error("unit glyph wrong");

  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_digit_position == PosUnits) |-> out_segment_pattern[SegW-1])
    else $error("decimal point missing");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_digit_position == PosGlyph)
    else $error("scan did not start at rightmost position");

endmodule

bind temperature_to_seven_segment_scan_top tsss_checker u_tsss_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_digit_position  (out_digit_position),
  .out_segment_pattern (out_segment_pattern),
  .out_last_position   (out_last_position)
);

`default_nettype wire
